// ===== src/qapa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qapa_pkg
// Shared widths, limits and register indexes of the quantized average pool
// accumulator.
// ----------------------------------------------------------------------------
package qapa_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CHAN_W     = 10;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned AREA_W     = 17;
  localparam int unsigned ZP_W       = 8;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned Q_SHIFT    = 16;

  localparam int unsigned PROD_W     = ZP_W + AREA_W;
  localparam int unsigned DIFF_W     = PROD_W + 1;
  localparam int unsigned MAG_W      = PROD_W;
  localparam int unsigned DVD_W      = MAG_W + SCALE_W;
  localparam int unsigned DVS_W      = AREA_W + Q_SHIFT;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 24;

  localparam int unsigned DEF_CHANNELS = 1024;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_AREA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_PAD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ZERO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_ZERO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RATIO = 3'd4;

endpackage
`default_nettype wire

// ===== src/qapa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qapa_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module qapa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/qapa_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qapa_div
// Restoring divider, one quotient bit per cycle, then a round to nearest,
// ties to even. The rounded quotient holds until the next start.
// ----------------------------------------------------------------------------
module qapa_div #(
  parameter int unsigned DVD_W = 49,
  parameter int unsigned DVS_W = 33
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_ROUND
  } div_state_e;

  div_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVD_W-1:0]  quo_q, quo_d;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_sub;
  logic [DVS_W:0] rem_dbl;
  logic           fits;
  logic           round_up;

  always_comb begin
    rem_sh   = {rem_q, quo_q[DVD_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs_q};
    fits     = rem_sh >= {1'b0, dvs_q};
    rem_dbl  = {rem_q, 1'b0};
    round_up = (rem_dbl > {1'b0, dvs_q}) || ((rem_dbl == {1'b0, dvs_q}) && quo_q[0]);

    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;

    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          rem_d   = '0;
          dvs_d   = divisor_i;
          quo_d   = dividend_i;
          step_d  = STEP_W'(DVD_W);
          state_d = DV_RUN;
        end
      end
      DV_RUN: begin
        rem_d  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_d  = {quo_q[DVD_W-2:0], fits};
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = DV_ROUND;
        end
      end
      DV_ROUND: begin
        quo_d   = quo_q + DVD_W'(round_up);
        done_d  = 1'b1;
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      rem_q   <= '0;
      dvs_q   <= '0;
      quo_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
      rem_q   <= rem_d;
      dvs_q   <= dvs_d;
      quo_q   <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == DV_IDLE))
    else $error("divider started while busy");

  a_done_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == DV_ROUND))
    else $error("divider done without round step");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DV_RUN) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

endmodule
`default_nettype wire

// ===== src/quantized_average_pool_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quantized_average_pool_accumulator
// Per-channel window sums of uint8 activations with a quantized average out.
//
// Input stream s_*: one activation per word; tdata holds pixel and channel,
// tuser marks the first element of a window, tlast the last one. Each channel
// keeps sum and count in one RAM entry (read, update, write back).
// Output stream m_*: one word per window close, the clamped quantized average
// and its channel.
// Config port: cfg_we_i writes register cfg_idx_i; 0 kernel_area,
// 1 exclude_pad, 2 src_zero, 3 dst_zero, 4 scale_ratio (Q8.16).
// A word without tlast is read from RAM, updated and written back before the
// next word is taken. A word with tlast then passes the product, difference
// and multiply states and the 49-step restoring divider, and waits in ST_FIN
// for a free output register; m_tvalid rises as the result is loaded there.
// A word with a channel at or above CHANNELS is dropped without a RAM update.
// A stalled receiver blocks the input stream only once the next window close
// waits in ST_FIN. Reset clears config to defaults and empties the output
// register; RAM contents are undefined until each channel starts a window.
// ----------------------------------------------------------------------------
module quantized_average_pool_accumulator #(
  parameter int unsigned CHANNELS = qapa_pkg::DEF_CHANNELS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // cfg
  input  wire logic                             cfg_we_i,
  input  wire logic [qapa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [qapa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [qapa_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] pixel, [17:8] chan
  input  wire logic                             s_tuser,  // [0] window_first
  input  wire logic                             s_tlast,
  // output stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [qapa_pkg::M_TDATA_W-1:0]   m_tdata   // [7:0] pooled, [17:8] out_chan
);

  import qapa_pkg::*;

  localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RAM_W = SUM_W + CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_PROD,
    ST_DIFF,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_FIN
  } state_e;

  // config
  logic [AREA_W-1:0]  kernel_area_q;
  logic               exclude_pad_q;
  logic [ZP_W-1:0]    src_zero_q;
  logic [ZP_W-1:0]    dst_zero_q;
  logic [SCALE_W-1:0] scale_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_area_q <= AREA_W'(1);
      exclude_pad_q <= 1'b0;
      src_zero_q    <= '0;
      dst_zero_q    <= '0;
      scale_ratio_q <= SCALE_W'(1) << Q_SHIFT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KERNEL_AREA: kernel_area_q <= cfg_data_i[AREA_W-1:0];
        REG_EXCLUDE_PAD: exclude_pad_q <= cfg_data_i[0];
        REG_SRC_ZERO:    src_zero_q    <= cfg_data_i[ZP_W-1:0];
        REG_DST_ZERO:    dst_zero_q    <= cfg_data_i[ZP_W-1:0];
        REG_SCALE_RATIO: scale_ratio_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [PIX_W-1:0]  in_pix;
  logic [CHAN_W-1:0] in_chan;
  logic [31:0]       in_chan_ext;
  logic              in_range;
  logic              accept;

  assign in_pix      = s_tdata[PIX_W-1:0];
  assign in_chan     = s_tdata[PIX_W +: CHAN_W];
  assign in_chan_ext = 32'(in_chan);
  assign in_range    = in_chan_ext < 32'(CHANNELS);

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic [PIX_W-1:0]  pooled_q, pooled_d;
  logic [CHAN_W-1:0] out_chan_q, out_chan_d;

  assign s_tready = (state_q == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // datapath registers
  logic [PIX_W-1:0]   pix_q;
  logic [CHAN_W-1:0]  chan_q;
  logic [AW-1:0]      addr_q;
  logic               first_q;
  logic               last_q;
  logic [SUM_W-1:0]   sum_q;
  logic [AREA_W-1:0]  area_q;
  logic [PROD_W-1:0]  prod_q;
  logic               neg_q;
  logic [MAG_W-1:0]   mag_q;
  logic [DVD_W-1:0]   dvd_q;

  // RAM
  logic [RAM_W-1:0] ram_rdata;
  logic [RAM_W-1:0] ram_wdata;
  logic             ram_we;
  logic [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0] rd_cnt;

  assign rd_sum = ram_rdata[SUM_W-1:0];
  assign rd_cnt = ram_rdata[SUM_W +: CNT_W];
  assign ram_we = (state_q == ST_UPD);

  qapa_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_chan_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // update
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  new_sum;
  logic [CNT_W-1:0]  new_cnt;
  logic [AREA_W-1:0] area_sel;
  logic [AREA_W-1:0] area_d;

  always_comb begin
    sum_ext  = {1'b0, rd_sum} + (SUM_W+1)'(pix_q);
    new_sum  = first_q ? SUM_W'(pix_q) : (sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0]);
    new_cnt  = first_q ? CNT_W'(1) : ((rd_cnt == CNT_MAX) ? CNT_MAX : rd_cnt + CNT_W'(1));
    area_sel = exclude_pad_q ? AREA_W'(new_cnt) : kernel_area_q;
    area_d   = (area_sel == '0) ? AREA_W'(1) : area_sel;
  end

  assign ram_wdata = {new_cnt, new_sum};

  // arithmetic
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] diff_neg;

  assign diff     = {2'b00, sum_q} - {1'b0, prod_q};
  assign diff_neg = -diff;

  // divider
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  assign div_start = (state_q == ST_DIVS);

  qapa_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  ({area_q, Q_SHIFT'(0)}),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // offset and clamp
  logic [DVD_W:0]   pos_tot;
  logic [PIX_W-1:0] result;
  logic             out_load;

  always_comb begin
    pos_tot = (DVD_W+1)'(div_quo) + (DVD_W+1)'(dst_zero_q);
    if (neg_q) begin
      result = (div_quo > DVD_W'(dst_zero_q)) ? '0 : dst_zero_q - div_quo[PIX_W-1:0];
    end else begin
      result = (pos_tot > (DVD_W+1)'(PIX_MAX)) ? PIX_MAX : pos_tot[PIX_W-1:0];
    end
  end

  assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= in_pix;
      chan_q  <= in_chan;
      addr_q  <= in_chan_ext[AW-1:0];
      first_q <= s_tuser;
      last_q  <= s_tlast;
    end
    if (state_q == ST_UPD) begin
      sum_q  <= new_sum;
      area_q <= area_d;
    end
    if (state_q == ST_PROD) begin
      prod_q <= PROD_W'(src_zero_q) * PROD_W'(area_q);
    end
    if (state_q == ST_DIFF) begin
      neg_q <= diff[DIFF_W-1];
      mag_q <= diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    end
    if (state_q == ST_MUL) begin
      dvd_q <= DVD_W'(mag_q) * DVD_W'(scale_ratio_q);
    end
  end

  // control
  always_comb begin
    state_d    = state_q;
    m_tvalid_d = m_tvalid_q;
    pooled_d   = pooled_q;
    out_chan_d = out_chan_q;

    if (m_tvalid_q && m_tready) begin
      m_tvalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_range) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD:  state_d = last_q ? ST_PROD : ST_IDLE;
      ST_PROD: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          m_tvalid_d = 1'b1;
          pooled_d   = result;
          out_chan_d = chan_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      pooled_q   <= '0;
      out_chan_q <= '0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
      pooled_q   <= pooled_d;
      out_chan_q <= out_chan_d;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = {(M_TDATA_W - CHAN_W - PIX_W)'(0), out_chan_q, pooled_q};

  a_write_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(s_tvalid && s_tready))
    else $error("RAM write without a preceding accepted word");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_tvalid_q || m_tready))
    else $error("output register overwritten while pending");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVW))
    else $error("divider result arrived outside wait state");

  a_area_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (area_q != '0))
    else $error("division started with zero area");

endmodule
`default_nettype wire

// ===== tb/quantized_average_pool_accumulator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quantized_average_pool_accumulator_test
// Self-checking bench for the quantized average pool accumulator.
//
// Sends windows of uint8 activations over the input stream. A bit-true
// predictor keeps the per-channel sums, counts and config and works out each
// pooled word. Every output word is compared in order against the oldest
// prediction. Directed checks cover reset defaults, config extremes, zero
// area, clamping, ties to even and one long back-to-back window. Random
// phases then interleave windows on several channels under random config,
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module quantized_average_pool_accumulator_test;
  import qapa_pkg::*;

  localparam int unsigned N_CHAN     = DEF_CHANNELS;
  localparam int unsigned SETTLE_CYC = 80;
  localparam int unsigned WDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORT = 10;
  localparam int unsigned N_PHASES   = 7;
  localparam int unsigned PHASE_LEN  = 150;
  localparam int unsigned LONG_LEN   = 300;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [PIX_W-1:0]  pooled;
  } pooled_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // [7:0] pixel, [17:8] chan
  logic                  s_tuser;   // [0] window_first
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // [7:0] pooled, [17:8] out_chan

  // predictor state
  logic [SUM_W-1:0]   win_sum [N_CHAN];
  logic [CNT_W-1:0]   win_cnt [N_CHAN];
  bit                 chan_open [N_CHAN];
  logic [AREA_W-1:0]  cfg_area  = AREA_W'(1);
  logic               cfg_excl  = 1'b0;
  logic [ZP_W-1:0]    cfg_src   = '0;
  logic [ZP_W-1:0]    cfg_dst   = '0;
  logic [SCALE_W-1:0] cfg_scale = 24'd65536;

  pooled_word_t pooled_q [$];
  bit           idle_on    = 1'b1;
  int           n_words    = 0;
  int           n_results  = 0;
  int           n_settings = 0;
  int           n_errors   = 0;
  int           quiet_cyc  = 0;

  quantized_average_pool_accumulator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic bit pool_predict(input logic [PIX_W-1:0] pix,
                                      input logic [CHAN_W-1:0] ch,
                                      input bit w_first, input bit w_last,
                                      output pooled_word_t res);
    longint sum, cnt, area, num, den, mag, quo, rem;
    bit     neg;
    res = '0;
    if (w_first) begin
      sum = longint'(pix);
      cnt = 1;
    end else begin
      sum = longint'(win_sum[ch]) + longint'(pix);
      if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
      cnt = longint'(win_cnt[ch]) + 1;
      if (cnt > longint'(CNT_MAX)) cnt = longint'(CNT_MAX);
    end
    win_sum[ch] = sum[SUM_W-1:0];
    win_cnt[ch] = cnt[CNT_W-1:0];
    if (!w_last) return 0;
    area = cfg_excl ? cnt : longint'(cfg_area);
    if (area == 0) area = 1;
    num = (sum - longint'(cfg_src) * area) * longint'(cfg_scale);
    den = area << Q_SHIFT;
    neg = num < 0;
    mag = neg ? -num : num;
    quo = mag / den;
    rem = mag % den;
    if (2 * rem > den || (2 * rem == den && quo[0])) quo++;
    if (neg) quo = -quo;
    quo = quo + longint'(cfg_dst);
    if (quo < 0) quo = 0;
    if (quo > longint'(PIX_MAX)) quo = longint'(PIX_MAX);
    res.pooled = quo[PIX_W-1:0];
    res.chan   = ch;
    return 1;
  endfunction

  task automatic send_word(input logic [PIX_W-1:0] pix, input logic [CHAN_W-1:0] ch,
                           input bit w_first, input bit w_last);
    int           gap;
    bit           first_eff;
    pooled_word_t res;
    gap = pick_gap();
    // never continue a channel that has not been started
    first_eff = w_first || !chan_open[ch];
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata  <= {{(S_TDATA_W-PIX_W-CHAN_W){1'b0}}, ch, pix};
    s_tuser  <= first_eff;
    s_tlast  <= w_last;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    chan_open[ch] = 1'b1;
    if (pool_predict(pix, ch, first_eff, w_last, res)) pooled_q.push_back(res);
    n_words++;
  endtask

  // drop valid, wait for all pooled words, then let the pipeline empty
  task automatic settle(input int extra);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_KERNEL_AREA: cfg_area  = val[AREA_W-1:0];
      REG_EXCLUDE_PAD: cfg_excl  = val[0];
      REG_SRC_ZERO:    cfg_src   = val[ZP_W-1:0];
      REG_DST_ZERO:    cfg_dst   = val[ZP_W-1:0];
      REG_SCALE_RATIO: cfg_scale = val[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int area, input bit excl, input int src, input int dst,
                            input int scale);
    settle(SETTLE_CYC);
    write_reg(REG_KERNEL_AREA, CFG_DATA_W'(area));
    write_reg(REG_EXCLUDE_PAD, CFG_DATA_W'(excl));
    write_reg(REG_SRC_ZERO,    CFG_DATA_W'(src));
    write_reg(REG_DST_ZERO,    CFG_DATA_W'(dst));
    write_reg(REG_SCALE_RATIO, CFG_DATA_W'(scale));
    n_settings++;
  endtask

  task automatic test_defaults();
    send_word(8'h00, 10'd0,     1'b1, 1'b1);
    send_word(8'hFF, 10'd1023,  1'b1, 1'b1);
    send_word(8'hAA, 10'h155,   1'b1, 1'b1);
    send_word(8'h0A, 10'h2AA,   1'b1, 1'b0);
    send_word(8'h55, 10'h2AA,   1'b0, 1'b1);
  endtask

  task automatic test_extremes();
    set_config(0, 1'b0, 0, 0, 65536);
    send_word(8'd200, 10'd5, 1'b1, 1'b1);
    set_config(65536, 1'b0, 0, 0, 24'hFFFFFF);
    send_word(8'hFF, 10'd5, 1'b1, 1'b0);
    send_word(8'hFF, 10'd5, 1'b0, 1'b1);
    set_config(4, 1'b0, 255, 0, 65536);
    send_word(8'h00, 10'd6, 1'b1, 1'b1);
    set_config(1, 1'b0, 0, 255, 65536);
    send_word(8'hFF, 10'd6, 1'b1, 1'b1);
    set_config(131071, 1'b0, 0, 0, 65536);
    // continue a closed window with no first mark
    send_word(8'd7, 10'd6, 1'b0, 1'b1);
    set_config(3, 1'b1, 0, 77, 0);
    send_word(8'd9, 10'd7, 1'b1, 1'b0);
    send_word(8'd9, 10'd7, 1'b0, 1'b0);
    send_word(8'd9, 10'd7, 1'b0, 1'b1);
  endtask

  task automatic test_rounding();
    set_config(2, 1'b1, 0, 0, 65536);
    send_word(8'd1, 10'd8, 1'b1, 1'b0);
    send_word(8'd0, 10'd8, 1'b0, 1'b1);
    send_word(8'd3, 10'd8, 1'b1, 1'b0);
    send_word(8'd0, 10'd8, 1'b0, 1'b1);
    send_word(8'd5, 10'd8, 1'b1, 1'b0);
    send_word(8'd0, 10'd8, 1'b0, 1'b1);
    set_config(2, 1'b1, 2, 10, 65536);
    send_word(8'd1, 10'd9, 1'b1, 1'b0);
    send_word(8'd0, 10'd9, 1'b0, 1'b1);
    send_word(8'd3, 10'd9, 1'b1, 1'b0);
    send_word(8'd0, 10'd9, 1'b0, 1'b1);
  endtask

  task automatic test_long_window();
    int total;
    total = int'(LONG_LEN);
    set_config(1, 1'b1, 0, 0, 65536);
    idle_on = 1'b0;
    for (int i = 0; i < total; i++) send_word(8'hFF, 10'd3, i == 0, i == total - 1);
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    logic [CHAN_W-1:0] chan_pool [8];
    int                left [8];
    int                k, area, scale, src, r;
    bit                w_first, w_last;
    logic [PIX_W-1:0]  pix;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      area  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 16);
      scale = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                          : $urandom_range(16384, 262144);
      src   = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 32);
      set_config(area, $urandom_range(0, 1), src, $urandom_range(0, 255), scale);
      idle_on = (ph != 2);
      for (int j = 0; j < 8; j++) begin
        chan_pool[j] = CHAN_W'($urandom_range(0, N_CHAN - 1));
        left[j]      = 0;
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) begin
          // broken sequence: stray marks anywhere
          w_first = $urandom_range(0, 1);
          w_last  = $urandom_range(0, 1);
          left[k] = w_last ? 0 : $urandom_range(1, 8);
        end else begin
          w_first = (left[k] == 0);
          if (w_first) begin
            r = $urandom_range(0, 99);
            left[k] = (r < 50) ? $urandom_range(1, 4) :
                      (r < 90) ? $urandom_range(5, 16) : $urandom_range(17, 64);
          end
          w_last = (left[k] == 1);
          left[k]--;
        end
        pix = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : PIX_W'($urandom_range(0, 255));
        send_word(pix, chan_pool[k], w_first, w_last);
        if (ph == 3 && i == PHASE_LEN / 2) settle(0);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : rx_ready
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    pooled_word_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[CHAN_W+PIX_W-1:0];
      n_results++;
      if (pooled_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORT)
          $display("unexpected word: chan %0d pooled %0d", got.chan, got.pooled);
      end else begin
        want = pooled_q.pop_front();
        if (got.pooled !== want.pooled || got.chan !== want.chan) begin
          n_errors++;
          if (n_errors <= MAX_REPORT)
            $display("mismatch: expected chan %0d pooled %0d, got chan %0d pooled %0d",
                     want.chan, want.pooled, got.chan, got.pooled);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cyc = 0;
    else quiet_cyc = quiet_cyc + 1;
    if (quiet_cyc >= WDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d pooled words pending",
               quiet_cyc, pooled_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    s_tlast    = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_extremes();
    test_rounding();
    test_long_window();
    test_random();
    settle(SETTLE_CYC);
    if (pooled_q.size() != 0) n_errors += pooled_q.size();
    $display("covered %0d input words and %0d pooled words over %0d register settings",
             n_words, n_results, n_settings);
    $display("incl. zero area, clamping, ties to even, a long window, windows without first mark");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
